/* hw/rtl/aabb_collision_pair_finder_core_assert.svh */
// Assertion macros for the collider pair finder core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef AABB_COLLISION_PAIR_FINDER_CORE_ASSERT_SVH
`define AABB_COLLISION_PAIR_FINDER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ACPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ACPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/acpf_pkg.sv */
// Shared types and constants of the collider pair finder.
// No dependencies; the RTL modules refer to it by scoped names, the testbench files import it.
package acpf_pkg;

  localparam int MASK_W = 25;
  localparam logic [MASK_W-1:0] MASK_RESET = 25'h210B80;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;

  // Result codes.
  localparam logic [1:0] RES_ADD    = 2'd0;
  localparam logic [1:0] RES_REMOVE = 2'd1;
  localparam logic [1:0] RES_PAIR   = 2'd2;
  localparam logic [1:0] RES_DONE   = 2'd3;

  // Highest collider type that takes part in the enable mask.
  localparam logic [2:0] KIND_WIN   = 3'd4;
  localparam logic [4:0] TYPE_COUNT = 5'd5;

  typedef logic [2:0] slot_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [2:0]         kind;
  } rect_entry_t;

  typedef struct packed {
    logic        we;
    slot_t       waddr;
    rect_entry_t wdata;
    logic        re;
    slot_t       raddr_a;
    slot_t       raddr_b;
  } mem_req_t;

endpackage

/* hw/rtl/acpf_in_if.sv */
// Input channel of the collider pair finder: valid/ready plus the item fields.
// No dependencies.
interface acpf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [2:0]         slot;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [14:0]        rect_w;
  logic [14:0]        rect_h;
  logic [2:0]         kind;

  modport source (output valid, op, slot, rect_x, rect_y, rect_w, rect_h, kind,
                  input ready);
  modport sink (input valid, op, slot, rect_x, rect_y, rect_w, rect_h, kind,
                output ready);
endinterface

/* hw/rtl/acpf_out_if.sv */
// Result channel of the collider pair finder: valid/ready plus the result fields.
// No dependencies.
interface acpf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [2:0] slot_a;
  logic [2:0] slot_b;
  logic       full_res;
  logic       last;

  modport source (output valid, result_kind, slot_a, slot_b, full_res, last,
                  input ready);
  modport sink (input valid, result_kind, slot_a, slot_b, full_res, last,
                output ready);
endinterface

/* hw/rtl/aabb_collision_pair_finder_core.sv */
// Top level of the collider pair finder: mask register, sequencer, table, pair test.
// Depends on acpf_pkg, acpf_in_if, acpf_out_if, acpf_store, acpf_pair_test, acpf_ctrl.
//
//   Channel  | Direction | Handshake          | Payload
//   in_ch    | in        | valid / ready      | op, slot, rect_x, rect_y, rect_w, rect_h, kind
//   out_ch   | out       | valid / ready      | result_kind, slot_a, slot_b, full_res, last
//   cfg      | in        | cfg_we (no wait)   | cfg_wdata = pair_enable_mask
//
// An add or remove item is acknowledged through the result register in the cycle after it
// is taken. A sweep walks all SLOTS*(SLOTS-1)/2 slot pairs, one pair per cycle while the
// output is not stalled, through the two read ports of the table, then tests the last pair
// and issues the done result before the next input can be taken. Output back-pressure
// holds the whole pair walk.
// Reset is synchronous and active low; the slot table itself has no reset, since entry data
// is used only for slots that an add has written. One item is in progress at a time.
module aabb_collision_pair_finder_core #(
  parameter int SLOTS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  acpf_in_if.sink                     in_ch,
  acpf_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [acpf_pkg::MASK_W-1:0] cfg_wdata
);

  // Type-pair enable mask: bit a*5+b allows a first collider of type a against a second of
  // type b.
  logic [acpf_pkg::MASK_W-1:0] mask_r;

  acpf_pkg::mem_req_t    mem_req;
  acpf_pkg::rect_entry_t rdata_a;
  acpf_pkg::rect_entry_t rdata_b;
  logic                  pair_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= acpf_pkg::MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // The sequencer keeps the live and pending slot bits in flip-flops and drives the table.
  acpf_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mem_req  (mem_req),
    .pair_hit (pair_hit)
  );

  // Rectangle and type table, one entry per slot, with registered read data.
  acpf_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk     (clk),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // The test works on the registered read data; the sequencer qualifies it with liveness.
  acpf_pair_test u_pair_test (
    .rect_a (rdata_a),
    .rect_b (rdata_b),
    .mask   (mask_r),
    .hit    (pair_hit)
  );

endmodule

/* hw/rtl/acpf_store.sv */
// Collider table memory: one write port and two registered read ports.
// Depends on acpf_pkg.
module acpf_store #(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  acpf_pkg::mem_req_t    req,
  output acpf_pkg::rect_entry_t rdata_a,
  output acpf_pkg::rect_entry_t rdata_b
);

  localparam int SLOT_AW = $clog2(SLOTS);

  acpf_pkg::rect_entry_t mem_r [SLOTS];
  acpf_pkg::rect_entry_t rd_a_r;
  acpf_pkg::rect_entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr[SLOT_AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_a_r <= mem_r[req.raddr_a[SLOT_AW-1:0]];
      rd_b_r <= mem_r[req.raddr_b[SLOT_AW-1:0]];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

/* hw/rtl/acpf_pair_test.sv */
// Pair test: type-pair enable lookup and strict rectangle overlap.
// Depends on acpf_pkg.
module acpf_pair_test (
  input  acpf_pkg::rect_entry_t         rect_a,
  input  acpf_pkg::rect_entry_t         rect_b,
  input  logic [acpf_pkg::MASK_W-1:0]   mask,
  output logic                          hit
);

  logic signed [16:0] ax_lo, ax_hi, ay_lo, ay_hi;
  logic signed [16:0] bx_lo, bx_hi, by_lo, by_hi;
  logic               overlap;
  logic               types_ok;
  logic [4:0]         bit_idx;
  logic [31:0]        mask_ext;

  // Edges widened by one bit so that right and bottom edges never wrap.
  always_comb begin
    ax_lo = {rect_a.x[15], rect_a.x};
    ay_lo = {rect_a.y[15], rect_a.y};
    bx_lo = {rect_b.x[15], rect_b.x};
    by_lo = {rect_b.y[15], rect_b.y};
    ax_hi = ax_lo + {2'b00, rect_a.w};
    ay_hi = ay_lo + {2'b00, rect_a.h};
    bx_hi = bx_lo + {2'b00, rect_b.w};
    by_hi = by_lo + {2'b00, rect_b.h};
    overlap = (ax_lo < bx_hi) && (ax_hi > bx_lo) && (ay_lo < by_hi) && (ay_hi > by_lo);
  end

  // Types beyond the last known type are never enabled.
  always_comb begin
    types_ok = (rect_a.kind <= acpf_pkg::KIND_WIN) && (rect_b.kind <= acpf_pkg::KIND_WIN);
    bit_idx  = 5'({2'b00, rect_a.kind} * acpf_pkg::TYPE_COUNT) + {2'b00, rect_b.kind};
    mask_ext = {{(32 - acpf_pkg::MASK_W){1'b0}}, mask};
  end

  assign hit = types_ok && mask_ext[bit_idx] && overlap;

endmodule

/* hw/rtl/acpf_ctrl.sv */
// Sequencer of the collider pair finder: slot bookkeeping, pair walk, result register.
// Depends on acpf_pkg, acpf_in_if, acpf_out_if and the assertion macro header.
`include "aabb_collision_pair_finder_core_assert.svh"

module acpf_ctrl #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  acpf_in_if.sink            in_ch,
  acpf_out_if.source         out_ch,
  output acpf_pkg::mem_req_t mem_req,
  input  logic               pair_hit
);

  localparam int SLOT_AW = $clog2(SLOTS);
  localparam logic [SLOT_AW-1:0] I_LAST = SLOT_AW'(SLOTS - 2);
  localparam logic [SLOT_AW-1:0] K_LAST = SLOT_AW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_TAIL  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [SLOTS-1:0]   pending_r, pending_nxt;
  logic [SLOT_AW-1:0] pi_r, pi_nxt;
  logic [SLOT_AW-1:0] pk_r, pk_nxt;

  // Stage holding the pair whose table entries sit in the read registers.
  logic               s1_vld_r, s1_vld_nxt;
  logic               s1_done_r, s1_done_nxt;
  logic               s1_live_r, s1_live_nxt;
  logic [SLOT_AW-1:0] s1_i_r, s1_i_nxt;
  logic [SLOT_AW-1:0] s1_k_r, s1_k_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         res_kind_r, res_kind_nxt;
  logic [2:0]         slot_a_r, slot_a_nxt;
  logic [2:0]         slot_b_r, slot_b_nxt;
  logic               full_r, full_nxt;
  logic               last_r, last_nxt;

  logic               adv;
  logic               acc;
  logic               free_found;
  logic [SLOT_AW-1:0] free_idx;
  logic               rm_in_range;
  logic [SLOT_AW-1:0] rm_idx;

  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && adv;
  assign acc = in_ch.valid && in_ch.ready;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!valid_r[j]) begin
        free_found = 1'b1;
        free_idx   = SLOT_AW'(j);
      end
    end
  end

  assign rm_in_range = ({1'b0, in_ch.slot} < 4'(SLOTS));
  assign rm_idx      = in_ch.slot[SLOT_AW-1:0];

  // Slot state, pair walk and table accesses.
  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    pending_nxt = pending_r;
    pi_nxt      = pi_r;
    pk_nxt      = pk_r;
    s1_vld_nxt  = s1_vld_r;
    s1_done_nxt = s1_done_r;
    s1_live_nxt = s1_live_r;
    s1_i_nxt    = s1_i_r;
    s1_k_nxt    = s1_k_r;

    mem_req.we          = 1'b0;
    mem_req.waddr       = 3'(free_idx);
    mem_req.wdata.x     = in_ch.rect_x;
    mem_req.wdata.y     = in_ch.rect_y;
    mem_req.wdata.w     = in_ch.rect_w;
    mem_req.wdata.h     = in_ch.rect_h;
    mem_req.wdata.kind  = in_ch.kind;
    mem_req.re          = 1'b0;
    mem_req.raddr_a     = 3'(pi_r);
    mem_req.raddr_b     = 3'(pk_r);

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_ch.op)
            acpf_pkg::OP_ADD: begin
              if (free_found) begin
                mem_req.we            = 1'b1;
                valid_nxt[free_idx]   = 1'b1;
                pending_nxt[free_idx] = 1'b0;
              end
            end
            acpf_pkg::OP_REMOVE: begin
              if (rm_in_range && valid_r[rm_idx]) begin
                pending_nxt[rm_idx] = 1'b1;
              end
            end
            acpf_pkg::OP_SWEEP: begin
              valid_nxt   = valid_r & ~pending_r;
              pending_nxt = '0;
              pi_nxt      = '0;
              pk_nxt      = SLOT_AW'(1);
              state_nxt   = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (adv) begin
          mem_req.re  = 1'b1;
          s1_vld_nxt  = 1'b1;
          s1_done_nxt = 1'b0;
          s1_live_nxt = valid_r[pi_r] && valid_r[pk_r];
          s1_i_nxt    = pi_r;
          s1_k_nxt    = pk_r;
          if (pk_r == K_LAST) begin
            if (pi_r == I_LAST) begin
              state_nxt = ST_TAIL;
            end else begin
              pi_nxt = pi_r + SLOT_AW'(1);
              pk_nxt = pi_r + SLOT_AW'(2);
            end
          end else begin
            pk_nxt = pk_r + SLOT_AW'(1);
          end
        end
      end
      ST_TAIL: begin
        if (adv) begin
          s1_vld_nxt  = 1'b1;
          s1_done_nxt = 1'b1;
          s1_live_nxt = 1'b0;
          state_nxt   = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (adv) begin
          s1_vld_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register: loads whenever the previous result has gone or is leaving.
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_kind_nxt  = res_kind_r;
    slot_a_nxt    = slot_a_r;
    slot_b_nxt    = slot_b_r;
    full_nxt      = full_r;
    last_nxt      = last_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      slot_b_nxt    = '0;
      full_nxt      = 1'b0;
      if (s1_vld_r) begin
        if (s1_done_r) begin
          out_valid_nxt = 1'b1;
          res_kind_nxt  = acpf_pkg::RES_DONE;
          slot_a_nxt    = '0;
          last_nxt      = 1'b1;
        end else if (s1_live_r && pair_hit) begin
          out_valid_nxt = 1'b1;
          res_kind_nxt  = acpf_pkg::RES_PAIR;
          slot_a_nxt    = 3'(s1_i_r);
          slot_b_nxt    = 3'(s1_k_r);
          last_nxt      = 1'b0;
        end
      end else if (acc && (in_ch.op == acpf_pkg::OP_ADD)) begin
        out_valid_nxt = 1'b1;
        res_kind_nxt  = acpf_pkg::RES_ADD;
        slot_a_nxt    = free_found ? 3'(free_idx) : 3'd0;
        full_nxt      = !free_found;
        last_nxt      = 1'b1;
      end else if (acc && (in_ch.op == acpf_pkg::OP_REMOVE)) begin
        out_valid_nxt = 1'b1;
        res_kind_nxt  = acpf_pkg::RES_REMOVE;
        slot_a_nxt    = in_ch.slot;
        last_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      pending_r   <= '0;
      pi_r        <= '0;
      pk_r        <= '0;
      s1_vld_r    <= 1'b0;
      s1_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pending_r   <= pending_nxt;
      pi_r        <= pi_nxt;
      pk_r        <= pk_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s1_done_r   <= s1_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_live_r  <= s1_live_nxt;
    s1_i_r     <= s1_i_nxt;
    s1_k_r     <= s1_k_nxt;
    res_kind_r <= res_kind_nxt;
    slot_a_r   <= slot_a_nxt;
    slot_b_r   <= slot_b_nxt;
    full_r     <= full_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = res_kind_r;
  assign out_ch.slot_a      = slot_a_r;
  assign out_ch.slot_b      = slot_b_r;
  assign out_ch.full_res    = full_r;
  assign out_ch.last        = last_r;

  `ACPF_ASSERT_SAME(a_pending_live, clk, rst_n, 1'b1, (pending_r & ~valid_r) == '0, "pending slot is not live")
  `ACPF_ASSERT_SAME(a_ready_empty, clk, rst_n, in_ch.ready, !s1_vld_r, "input taken with a pair in flight")
  `ACPF_ASSERT_SAME(a_done_drain, clk, rst_n, s1_vld_r && s1_done_r, state_r == ST_DRAIN, "done token outside drain")
  `ACPF_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_r && !out_ch.ready && (state_r == ST_SWEEP), (state_r == ST_SWEEP) && $stable(pi_r) && $stable(pk_r), "pair walk moved under stall")

endmodule

/* dv/acpf_tb_pkg.sv */
`timescale 1ns / 1ps
// Testbench package for the collider pair finder: item and result types and the table tracker.
// Depends on acpf_pkg for the operation and result codes, the mask width and the entry type.
package acpf_tb_pkg;
  import acpf_pkg::*;

  localparam int N_SLOTS = 8;
  localparam int REPORT_MAX = 10;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Collider types; KIND_WIN comes from acpf_pkg.
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_PLAYER = 3'd1;
  localparam logic [2:0] KIND_GROUND = 3'd2;
  localparam logic [2:0] KIND_DEAD   = 3'd3;
  localparam logic [2:0] KIND_BEYOND = 3'd7;

  typedef struct packed {
    logic [1:0]         op;
    slot_t              slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [2:0]         kind;
  } collider_item_t;

  typedef struct packed {
    logic [1:0] code;
    slot_t      slot_a;
    slot_t      slot_b;
    logic       full;
    logic       last;
  } pair_result_t;

  class collider_table_tracker;
    logic [MASK_W-1:0] pair_mask;
    bit [N_SLOTS-1:0]  live;
    bit [N_SLOTS-1:0]  doomed;
    rect_entry_t       entries [N_SLOTS];
    pair_result_t      awaited [$];
    int                failures;
    int                reported;

    function new();
      pair_mask = MASK_RESET;
      live = '0;
      doomed = '0;
      failures = 0;
      reported = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void set_mask(logic [MASK_W-1:0] value);
      pair_mask = value;
    endfunction

    function bit idle();
      return awaited.size() == 0;
    endfunction

    function pair_result_t result_of(logic [1:0] code, int a, int b, logic full, logic last);
      pair_result_t r;
      r.code = code;
      r.slot_a = slot_t'(a);
      r.slot_b = slot_t'(b);
      r.full = full;
      r.last = last;
      return r;
    endfunction

    function string describe(pair_result_t r);
      return $sformatf("code %0d slot_a %0d slot_b %0d full %0b last %0b",
                       r.code, r.slot_a, r.slot_b, r.full, r.last);
    endfunction

    // Types above the win type never take part in the mask.
    function bit pair_allowed(logic [2:0] ta, logic [2:0] tb);
      int idx;
      if (ta > KIND_WIN || tb > KIND_WIN) return 1'b0;
      idx = int'(ta) * int'(TYPE_COUNT) + int'(tb);
      return pair_mask[idx];
    endfunction

    // Strict overlap in full integer range, so edges that only touch do not count.
    function bit boxes_overlap(rect_entry_t a, rect_entry_t b);
      int ax, ay, aw, ah, bx, by, bw, bh;
      ax = $signed(a.x);
      ay = $signed(a.y);
      aw = int'(a.w);
      ah = int'(a.h);
      bx = $signed(b.x);
      by = $signed(b.y);
      bw = int'(b.w);
      bh = int'(b.h);
      return ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
    endfunction

    function void sweep_pairs();
      live &= ~doomed;
      doomed = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
        for (int k = i + 1; k < N_SLOTS; k++) begin
          if (live[i] && live[k] && pair_allowed(entries[i].kind, entries[k].kind) &&
              boxes_overlap(entries[i], entries[k])) begin
            awaited.push_back(result_of(RES_PAIR, i, k, 1'b0, 1'b0));
          end
        end
      end
      awaited.push_back(result_of(RES_DONE, 0, 0, 1'b0, 1'b1));
    endfunction

    function void take_item(collider_item_t it);
      int free_slot;
      free_slot = -1;
      case (it.op)
        OP_ADD: begin
          for (int i = N_SLOTS - 1; i >= 0; i--) begin
            if (!live[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            awaited.push_back(result_of(RES_ADD, 0, 0, 1'b1, 1'b1));
          end else begin
            entries[free_slot].x = it.x;
            entries[free_slot].y = it.y;
            entries[free_slot].w = it.w;
            entries[free_slot].h = it.h;
            entries[free_slot].kind = it.kind;
            live[free_slot] = 1'b1;
            doomed[free_slot] = 1'b0;
            awaited.push_back(result_of(RES_ADD, free_slot, 0, 1'b0, 1'b1));
          end
        end
        OP_REMOVE: begin
          if (live[it.slot]) doomed[it.slot] = 1'b1;
          awaited.push_back(result_of(RES_REMOVE, int'(it.slot), 0, 1'b0, 1'b1));
        end
        OP_SWEEP: sweep_pairs();
        default: ;
      endcase
    endfunction

    function void check_result(pair_result_t got);
      pair_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (reported < REPORT_MAX) $display("result with nothing awaited: %s", describe(got));
        reported++;
        return;
      end
      want = awaited.pop_front();
      if (got.code !== want.code || got.slot_a !== want.slot_a ||
          got.slot_b !== want.slot_b || got.full !== want.full || got.last !== want.last) begin
        failures++;
        if (reported < REPORT_MAX) begin
          $display("mismatch: expected %s", describe(want));
          $display("          actual   %s", describe(got));
        end
        reported++;
      end
    endfunction
  endclass

endpackage

/* dv/aabb_collision_pair_finder_core_tb.sv */
`timescale 1ns / 1ps
// Top level of the collider pair finder testbench: clock, reset, drivers and the run sequence.
// Depends on acpf_pkg, acpf_tb_pkg, the two channel interfaces and the block itself.
module aabb_collision_pair_finder_core_tb;
  import acpf_pkg::*;
  import acpf_tb_pkg::*;

  // The settle margin covers the end of a sweep, start-up and drain.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  // Idling controls: a calm side never pauses between transfers.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int hold_len = 0;
  bit hold_active = 1'b0;

  collider_table_tracker tracker = new();

  acpf_in_if  in_ch ();
  acpf_out_if out_ch ();

  aabb_collision_pair_finder_core #(
    .SLOTS(N_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Inputs change on the falling edge only, so the block always samples settled values.
  task automatic offer_item(input collider_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op = it.op;
    in_ch.slot = it.slot;
    in_ch.rect_x = it.x;
    in_ch.rect_y = it.y;
    in_ch.rect_w = it.w;
    in_ch.rect_h = it.h;
    in_ch.kind = it.kind;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // The transfer took place at this edge; the expectation is noted straight away, while
    // results are only compared on the falling edge, so the order cannot be confused.
    tracker.take_item(it);
    @(negedge clk);
  endtask

  // Waits until every awaited result has arrived and the block has had time to finish
  // any ignored item, so that it is idle for a register write.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (!tracker.idle()) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] value);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_mask(value);
  endtask

  function automatic collider_item_t collider(int x, int y, int w, int h, logic [2:0] kind);
    collider_item_t it;
    it = '0;
    it.op = OP_ADD;
    it.x = 16'(x);
    it.y = 16'(y);
    it.w = 15'(w);
    it.h = 15'(h);
    it.kind = kind;
    return it;
  endfunction

  function automatic collider_item_t command(logic [1:0] op, int slot);
    collider_item_t it;
    it = '0;
    it.op = op;
    it.slot = slot_t'(slot);
    return it;
  endfunction

  // Mostly adds of small rectangles around the origin, so that many pairs overlap, plus
  // removals of live slots and frequent sweeps. A few items carry fully random fields.
  function automatic collider_item_t random_item();
    collider_item_t it;
    int pick;
    int s;
    bit [N_SLOTS-1:0] occupied;
    pick = $urandom_range(0, 99);
    it.op = OP_ADD;
    it.slot = slot_t'($urandom_range(0, 7));
    it.x = 16'($urandom);
    it.y = 16'($urandom);
    it.w = 15'($urandom);
    it.h = 15'($urandom);
    it.kind = 3'($urandom_range(0, 7));
    if (pick < 45) begin
      if ($urandom_range(0, 6) != 0) begin
        it.x = 16'(int'($urandom_range(0, 400)) - 200);
        it.y = 16'(int'($urandom_range(0, 400)) - 200);
        it.w = 15'($urandom_range(0, 150));
        it.h = 15'($urandom_range(0, 150));
      end
      if ($urandom_range(0, 9) != 0) it.kind = 3'($urandom_range(1, 4));
    end else if (pick < 70) begin
      it.op = OP_REMOVE;
      occupied = tracker.live;
      if (occupied != '0 && $urandom_range(0, 4) != 0) begin
        do s = $urandom_range(0, N_SLOTS - 1); while (!occupied[s]);
        it.slot = slot_t'(s);
      end
    end else if (pick < 94) begin
      it.op = OP_SWEEP;
    end else if (pick < 97) begin
      it.op = OP_UNUSED;
    end else begin
      it.op = 2'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // Result side: each transfer draws its own pause, and a long hold-off from the
  // back-pressure process keeps ready low for as long as it lasts.
  initial begin : result_sink
    pair_result_t seen;
    int gap;
    bit took;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      took = 1'b0;
      while (!took) begin
        out_ch.ready = !hold_active;
        @(posedge clk);
        if (out_ch.ready && out_ch.valid) begin
          took = 1'b1;
          seen.code = out_ch.result_kind;
          seen.slot_a = out_ch.slot_a;
          seen.slot_b = out_ch.slot_b;
          seen.full = out_ch.full_res;
          seen.last = out_ch.last;
        end
        @(negedge clk);
        if (took) tracker.check_result(seen);
      end
    end
  end

  // Long receiver hold-off, counted here on rising edges so that the sink, which reads
  // the flag on falling edges, always sees a settled value.
  initial begin : back_pressure
    forever begin
      wait (hold_len > 0);
      @(posedge clk);
      hold_active = 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_active = 1'b0;
      hold_len = 0;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : run_sequence
    collider_item_t    script [$];
    logic [MASK_W-1:0] phase_masks [5];
    collider_item_t    it;
    int                counted;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD;
    in_ch.slot = '0;
    in_ch.rect_x = '0;
    in_ch.rect_y = '0;
    in_ch.rect_w = '0;
    in_ch.rect_h = '0;
    in_ch.kind = KIND_NONE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset mask. The table is filled with the field extremes,
    // a zero-width box, a type above the win type, a none type and two boxes whose edges
    // only touch, then an add on a full table follows.
    script.push_back(command(OP_SWEEP, 0));
    script.push_back(collider(-32768, -32768, 32767, 32767, KIND_PLAYER));
    script.push_back(collider(0, 0, 32767, 32767, KIND_GROUND));
    script.push_back(collider(-100, -100, 200, 200, KIND_GROUND));
    script.push_back(collider(32767, 32767, 32767, 32767, KIND_DEAD));
    script.push_back(collider(-50, -50, 0, 10, KIND_WIN));
    script.push_back(collider(-10, -10, 20, 20, KIND_BEYOND));
    script.push_back(collider(-20, -20, 40, 40, KIND_NONE));
    script.push_back(collider(100, -100, 50, 50, KIND_PLAYER));
    script.push_back(collider(5, 5, 5, 5, KIND_GROUND));
    script.push_back(command(OP_SWEEP, 0));
    // Removing the same slot twice leaves it merely pending; an add before the sweep
    // still finds the table full, since pending slots stay live.
    script.push_back(command(OP_REMOVE, 2));
    script.push_back(command(OP_REMOVE, 2));
    script.push_back(command(OP_REMOVE, 3));
    script.push_back(command(OP_UNUSED, 5));
    script.push_back(collider(1, 1, 1, 1, KIND_WIN));
    script.push_back(command(OP_SWEEP, 0));
    // A removal of a slot that is already free is acknowledged without effect.
    script.push_back(command(OP_REMOVE, 2));
    script.push_back(collider(90, -80, 30, 30, KIND_GROUND));
    script.push_back(command(OP_SWEEP, 0));
    script.push_back(command(OP_REMOVE, 7));
    script.push_back(command(OP_REMOVE, 0));
    script.push_back(command(OP_SWEEP, 0));
    foreach (script[i]) offer_item(script[i]);

    // Random phases, each under its own mask: all pairs on, all off, two random masks
    // and finally the reset value again.
    phase_masks[0] = {MASK_W{1'b1}};
    phase_masks[1] = '0;
    phase_masks[2] = MASK_W'($urandom);
    phase_masks[3] = MASK_W'($urandom);
    phase_masks[4] = MASK_RESET;
    for (int p = 0; p < 5; p++) begin
      settle();
      write_mask(phase_masks[p]);
      // Phase one has no idling on either side; phase two lets the sender stream while
      // the receiver holds off, so the block backs up and stalls its input.
      tx_calm = (p == 1 || p == 2);
      rx_calm = (p == 1 || p == 4);
      if (p == 2) hold_len = HOLD_CYCLES;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        offer_item(it);
        if (it.op != OP_UNUSED) counted++;
      end
    end

    settle();
    if (tracker.failures == 0 && tracker.idle()) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
